>>> hw/rtl/encoder_speed_pi_pwm_macros.svh
// ----------------------------------------------------------------------------
// Encoder speed PI PWM assertion macros
// Shared concurrent assertion forms for the speed controller RTL.
// ----------------------------------------------------------------------------
`ifndef ENCODER_SPEED_PI_PWM_MACROS_SVH
`define ENCODER_SPEED_PI_PWM_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ESP_ASSERT_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ESP_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/esp_pkg.sv
// ----------------------------------------------------------------------------
// Encoder speed PI PWM package
// Shared types, register indexes and reset values of the speed controller.
// ----------------------------------------------------------------------------
package esp_pkg;

   // Event kinds carried on the request tuser
   localparam logic [1:0] MODE_EDGE_A = 2'd0;
   localparam logic [1:0] MODE_EDGE_B = 2'd1;
   localparam logic [1:0] MODE_TICK   = 2'd2;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_UPDATE_PERIOD   = 3'd0;
   localparam logic [2:0] CSR_COUNT_TO_SPEED  = 3'd1;
   localparam logic [2:0] CSR_GAIN_NOW        = 3'd2;
   localparam logic [2:0] CSR_GAIN_PREV       = 3'd3;
   localparam logic [2:0] CSR_VOLTAGE_LIMIT   = 3'd4;
   localparam logic [2:0] CSR_PWM_CENTER      = 3'd5;
   localparam logic [2:0] CSR_VOLTS_TO_COUNTS = 3'd6;
   localparam logic [2:0] CSR_PWM_PERIOD      = 3'd7;

   // Register reset values
   localparam logic [9:0]  RST_UPDATE_PERIOD   = 10'd50;
   localparam logic [15:0] RST_COUNT_TO_SPEED  = 16'd3310;
   localparam logic [14:0] RST_GAIN_NOW        = 15'd11725;
   localparam logic [15:0] RST_GAIN_PREV       = 16'hE7AF;  // -6225
   localparam logic [15:0] RST_VOLTAGE_LIMIT   = 16'd44237;
   localparam logic [11:0] RST_PWM_CENTER      = 12'd800;
   localparam logic [15:0] RST_VOLTS_TO_COUNTS = 16'd17067;
   localparam logic [11:0] RST_PWM_PERIOD      = 12'd1600;

   // Largest measured speed magnitude, Q5.12
   localparam int SPEED_MAX = 131071;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_BACK = 2'd2
   } dir_type;

   typedef struct packed {
      logic [9:0]  update_period;
      logic [15:0] count_to_speed;
      logic [14:0] gain_now;
      logic [15:0] gain_prev;
      logic [15:0] voltage_limit;
      logic [11:0] pwm_center;
      logic [15:0] volts_to_counts;
      logic [11:0] pwm_period;
   } csr_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAG,
      ST_SPEED,
      ST_PI,
      ST_DRIVE,
      ST_SCALE,
      ST_OFFSET,
      ST_DONE
   } back_state_type;

endpackage

>>> hw/rtl/encoder_speed_pi_pwm.sv
// ----------------------------------------------------------------------------
// Encoder speed PI PWM controller
// Quadrature edge counting, windowed speed measurement, incremental PI
// speed control and complementary PWM compare generation.
// ----------------------------------------------------------------------------
// Feed encoder edges (tuser 0 = channel A, 1 = channel B) and PWM period
// ticks (tuser 2) on the req_ stream; tuser 3 is ignored. Edge and tick words
// are taken one per cycle. A tick that closes a window of update_period
// ticks returns exactly one rsp_ word with the compare values, measured
// speed and drive; every other word returns nothing. The window snapshot is
// handed to a sequencer through a two-entry queue, and the sequencer takes
// each update through one registered step apiece for the queue pop, the
// count scaling multiply, speed and error, the two PI gain multiplies, the
// drive clamp, the compare scaling multiply, the offset, and the output
// load, which waits while the last result is not yet taken. The stream keeps
// one word per cycle while the queue has room; with the queue full,
// req_tready drops until the sequencer pops.
// A finished result waits in the output register while the next snapshot is
// already being processed. Write registers over csr_ only while idle.
// ----------------------------------------------------------------------------
module encoder_speed_pi_pwm
   import esp_pkg::*;
#(
   parameter int COUNT_BITS = 16,
   parameter int FRAC_BITS  = 12
)(
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [1:0] pin_levels, [16:2] speed_ref, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] mode
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [11:0] compare_a, [23:12] compare_b,
                                    // [41:24] speed, [58:42] drive, rest zero
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int QW = COUNT_BITS + 17;

   csr_type          csr_ff;
   queue_status_type q_status;
   logic             push, pop;
   logic [QW-1:0]    push_data, pop_data;
   logic [11:0]      compare_a, compare_b;
   logic signed [17:0] speed;
   logic signed [16:0] drive;

   // Register file: always ready, indexes follow the register list
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.update_period   <= RST_UPDATE_PERIOD;
         csr_ff.count_to_speed  <= RST_COUNT_TO_SPEED;
         csr_ff.gain_now        <= RST_GAIN_NOW;
         csr_ff.gain_prev       <= RST_GAIN_PREV;
         csr_ff.voltage_limit   <= RST_VOLTAGE_LIMIT;
         csr_ff.pwm_center      <= RST_PWM_CENTER;
         csr_ff.volts_to_counts <= RST_VOLTS_TO_COUNTS;
         csr_ff.pwm_period      <= RST_PWM_PERIOD;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_UPDATE_PERIOD:   csr_ff.update_period   <= csr_data[9:0];
            CSR_COUNT_TO_SPEED:  csr_ff.count_to_speed  <= csr_data;
            CSR_GAIN_NOW:        csr_ff.gain_now        <= csr_data[14:0];
            CSR_GAIN_PREV:       csr_ff.gain_prev       <= csr_data;
            CSR_VOLTAGE_LIMIT:   csr_ff.voltage_limit   <= csr_data;
            CSR_PWM_CENTER:      csr_ff.pwm_center      <= csr_data[11:0];
            CSR_VOLTS_TO_COUNTS: csr_ff.volts_to_counts <= csr_data;
            CSR_PWM_PERIOD:      csr_ff.pwm_period      <= csr_data[11:0];
            default: begin
            end
         endcase
      end
   end

   // Front end: count edges and ticks, snapshot the window on update
   esp_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .mode          (req_tuser),
      .pin_levels    (req_tdata[1:0]),
      .speed_ref     ($signed(req_tdata[16:2])),
      .update_period (csr_ff.update_period),
      .q_status      (q_status),
      .push          (push),
      .push_data     (push_data)
   );

   // Hold up to two pending updates
   esp_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_status  (q_status)
   );

   // Back end: speed, PI step and compare values
   esp_back #(
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (csr_ff),
      .q_status  (q_status),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .compare_a (compare_a),
      .compare_b (compare_b),
      .speed     (speed),
      .drive     (drive)
   );

   // Pack the result word, lowest field first
   assign rsp_tdata = {5'b0, drive, speed, compare_b, compare_a};

endmodule

>>> hw/rtl/esp_front.sv
// ----------------------------------------------------------------------------
// Encoder speed PI PWM front end
// Counts encoder edges and PWM ticks, tracks direction, and queues a
// snapshot of the measurement window on every controller update.
// ----------------------------------------------------------------------------
module esp_front
   import esp_pkg::*;
#(
   parameter int COUNT_BITS = 16
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               mode,
   input  logic [1:0]               pin_levels,
   input  logic signed [14:0]       speed_ref,
   input  logic [9:0]               update_period,
   input  queue_status_type         q_status,
   output logic                     push,
   output logic [COUNT_BITS+16:0]   push_data
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [COUNT_BITS-1:0] edge_count_ff, edge_count_in;
   logic [9:0]            tick_count_ff, tick_count_in;
   dir_type               direction_ff, direction_in;
   logic [9:0]            tick_next;
   logic                  accept;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign tick_next = tick_count_ff + 10'd1;

   always_comb begin
      edge_count_in = edge_count_ff;
      tick_count_in = tick_count_ff;
      direction_in  = direction_ff;
      push          = 1'b0;
      if (accept) begin
         unique case (mode)
            MODE_EDGE_A: begin
               if (edge_count_ff != COUNT_MAX) begin
                  edge_count_in = edge_count_ff + COUNT_BITS'(1);
               end
               if (pin_levels[0]) begin
                  direction_in = pin_levels[1] ? DIR_FWD : DIR_BACK;
               end
            end
            MODE_EDGE_B: begin
               if (edge_count_ff != COUNT_MAX) begin
                  edge_count_in = edge_count_ff + COUNT_BITS'(1);
               end
            end
            MODE_TICK: begin
               if (tick_next < update_period) begin
                  tick_count_in = tick_next;
               end else begin
                  // close the window: hand the snapshot to the back end
                  tick_count_in = '0;
                  edge_count_in = '0;
                  push          = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign push_data = {speed_ref, direction_ff, edge_count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_count_ff <= '0;
         tick_count_ff <= '0;
         direction_ff  <= DIR_NONE;
      end else begin
         edge_count_ff <= edge_count_in;
         tick_count_ff <= tick_count_in;
         direction_ff  <= direction_in;
      end
   end

endmodule

>>> hw/rtl/esp_queue.sv
// ----------------------------------------------------------------------------
// Encoder speed PI PWM update queue
// Two-entry FIFO of window snapshots between front and back end.
// ----------------------------------------------------------------------------
`include "encoder_speed_pi_pwm_macros.svh"

module esp_queue
   import esp_pkg::*;
#(
   parameter int WIDTH = 33
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type q_status
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff, count_in;

   assign q_status.full  = (count_ff == 2'd2);
   assign q_status.empty = (count_ff == 2'd0);
   assign pop_data       = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   `ESP_ASSERT_IMPLIES(a_no_push_when_full, clock, reset, push, !q_status.full || pop, "queue overflow")
   `ESP_ASSERT_IMPLIES(a_no_pop_when_empty, clock, reset, pop, !q_status.empty, "queue underflow")

endmodule

>>> hw/rtl/esp_back.sv
// ----------------------------------------------------------------------------
// Encoder speed PI PWM back end
// Sequencer that turns a window snapshot into speed, PI drive and PWM
// compare values, with the multiplies spread over separate steps, and holds the result word.
// ----------------------------------------------------------------------------
`include "encoder_speed_pi_pwm_macros.svh"

module esp_back
   import esp_pkg::*;
#(
   parameter int COUNT_BITS = 16,
   parameter int FRAC_BITS  = 12
)(
   input  logic                   clock,
   input  logic                   reset,
   input  csr_type                cfg,
   input  queue_status_type       q_status,
   input  logic [COUNT_BITS+16:0] pop_data,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [11:0]            compare_a,
   output logic [11:0]            compare_b,
   output logic signed [17:0]     speed,
   output logic signed [16:0]     drive
);

   localparam int MW     = COUNT_BITS + 16;
   localparam int MSHIFT = 16 - FRAC_BITS;
   localparam int OSHIFT = FRAC_BITS + 8;

   back_state_type state_ff, state_in;

   logic [COUNT_BITS-1:0]  count_ff;
   dir_type                dir_ff;
   logic signed [14:0]     ref_ff;
   logic [MW-1:0]          mag_prod_ff, mag_prod_in;
   logic [MW-1:0]          mag_shift;
   logic [16:0]            mag_sat;
   logic signed [17:0]     speed_ff, speed_in;
   logic signed [18:0]     error_ff, error_in;
   logic signed [34:0]     p_now_ff, p_now_in, p_prev_ff, p_prev_in;
   logic signed [35:0]     acc;
   logic signed [36:0]     drive_sum, lim;
   logic signed [16:0]     drive_ff, drive_in;
   logic signed [16:0]     drive_level_ff;
   logic signed [18:0]     prev_error_ff;
   logic signed [33:0]     scaled_ff, scaled_in;
   logic [33:0]            scaled_abs, scaled_shift;
   logic signed [18:0]     offset_ff, offset_in;
   logic signed [19:0]     ca_sum;
   logic [11:0]            ca;
   logic                   out_load;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [11:0]            compare_a_ff, compare_b_ff;
   logic signed [17:0]     speed_out_ff;
   logic signed [16:0]     drive_out_ff;

   // speed magnitude, saturation, sign and error
   assign mag_shift   = mag_prod_ff >> MSHIFT;
   assign mag_sat     = (mag_shift > MW'(SPEED_MAX)) ? 17'(SPEED_MAX) : mag_shift[16:0];
   assign mag_prod_in = MW'(count_ff) * MW'(cfg.count_to_speed);

   always_comb begin
      case (dir_ff)
         DIR_FWD:  speed_in = $signed({1'b0, mag_sat});
         DIR_BACK: speed_in = -$signed({1'b0, mag_sat});
         default:  speed_in = '0;
      endcase
   end

   assign error_in  = 19'(ref_ff) - 19'(speed_in);
   assign p_now_in  = 35'($signed({1'b0, cfg.gain_now})) * 35'(error_ff);
   assign p_prev_in = 35'($signed(cfg.gain_prev)) * 35'(prev_error_ff);

   // incremental PI update with floor scaling and symmetric clamp
   assign acc       = 36'(p_now_ff) + 36'(p_prev_ff);
   assign drive_sum = 37'(drive_level_ff) + 37'(acc >>> FRAC_BITS);
   assign lim       = $signed({21'b0, cfg.voltage_limit});

   always_comb begin
      if (drive_sum > lim) begin
         drive_in = 17'(lim);
      end else if (drive_sum < -lim) begin
         drive_in = 17'(-lim);
      end else begin
         drive_in = 17'(drive_sum);
      end
   end

   // compare offset truncates toward zero
   assign scaled_in    = 34'(drive_ff) * 34'($signed({1'b0, cfg.volts_to_counts}));
   assign scaled_abs   = scaled_ff[33] ? 34'(-scaled_ff) : 34'(scaled_ff);
   assign scaled_shift = scaled_abs >> OSHIFT;
   assign offset_in    = scaled_ff[33] ? -$signed(19'(scaled_shift))
                                       : $signed(19'(scaled_shift));

   assign ca_sum = $signed({8'b0, cfg.pwm_center}) + 20'(offset_ff);

   always_comb begin
      if (ca_sum < 20'sd0) begin
         ca = '0;
      end else if (ca_sum > $signed({8'b0, cfg.pwm_period})) begin
         ca = cfg.pwm_period;
      end else begin
         ca = 12'(ca_sum);
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      pop          = 1'b0;
      out_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               state_in = ST_MAG;
            end
         end
         ST_MAG:    state_in = ST_SPEED;
         ST_SPEED:  state_in = ST_PI;
         ST_PI:     state_in = ST_DRIVE;
         ST_DRIVE:  state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_OFFSET;
         ST_OFFSET: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (pop) begin
         count_ff <= pop_data[COUNT_BITS-1:0];
         dir_ff   <= dir_type'(pop_data[COUNT_BITS+1:COUNT_BITS]);
         ref_ff   <= $signed(pop_data[COUNT_BITS+16:COUNT_BITS+2]);
      end
      if (state_ff == ST_MAG) begin
         mag_prod_ff <= mag_prod_in;
      end
      if (state_ff == ST_SPEED) begin
         speed_ff <= speed_in;
         error_ff <= error_in;
      end
      if (state_ff == ST_PI) begin
         p_now_ff  <= p_now_in;
         p_prev_ff <= p_prev_in;
      end
      if (state_ff == ST_DRIVE) begin
         drive_ff <= drive_in;
      end
      if (state_ff == ST_SCALE) begin
         scaled_ff <= scaled_in;
      end
      if (state_ff == ST_OFFSET) begin
         offset_ff <= offset_in;
      end
      if (out_load) begin
         compare_a_ff <= ca;
         compare_b_ff <= cfg.pwm_period - ca;
         speed_out_ff <= speed_ff;
         drive_out_ff <= drive_ff;
      end
   end

   // controller memory
   always_ff @(posedge clock) begin
      if (reset) begin
         drive_level_ff <= '0;
         prev_error_ff  <= '0;
      end else if (state_ff == ST_DRIVE) begin
         drive_level_ff <= drive_in;
         prev_error_ff  <= error_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign compare_a = compare_a_ff;
   assign compare_b = compare_b_ff;
   assign speed     = speed_out_ff;
   assign drive     = drive_out_ff;

   `ESP_ASSERT_IMPLIES(a_compare_in_range, clock, reset, rsp_valid_ff, compare_a_ff <= cfg.pwm_period, "compare_a above period")
   `ESP_ASSERT_IMPLIES(a_compare_pair, clock, reset, rsp_valid_ff, 13'(compare_a_ff) + 13'(compare_b_ff) == 13'(cfg.pwm_period), "compare pair mismatch")
   `ESP_ASSERT_IMPLIES(a_pop_only_idle, clock, reset, pop, state_ff == ST_IDLE, "pop outside idle")

endmodule
